@@ src/idtc_pkg.sv @@
// Package for the ISO 8601 date-time checker: phase codes, character codes
// and the month length table. Depends on nothing.
`timescale 1ns / 1ps

package idtc_pkg;

  typedef enum logic [4:0] {
    PH_YEAR0   = 5'd0,
    PH_YEAR1   = 5'd1,
    PH_YEAR2   = 5'd2,
    PH_YEAR3   = 5'd3,
    PH_DASH1   = 5'd4,
    PH_MON0    = 5'd5,
    PH_MON1    = 5'd6,
    PH_DASH2   = 5'd7,
    PH_DAY0    = 5'd8,
    PH_DAY1    = 5'd9,
    PH_TEE     = 5'd10,
    PH_HOUR0   = 5'd11,
    PH_HOUR1   = 5'd12,
    PH_COLON1  = 5'd13,
    PH_MIN0    = 5'd14,
    PH_MIN1    = 5'd15,
    PH_COLON2  = 5'd16,
    PH_SEC0    = 5'd17,
    PH_SEC1    = 5'd18,
    PH_AFTSEC  = 5'd19,
    PH_FRAC0   = 5'd20,
    PH_FRACN   = 5'd21,
    PH_AFTFRAC = 5'd22,
    PH_OFFH0   = 5'd23,
    PH_OFFH1   = 5'd24,
    PH_COLON3  = 5'd25,
    PH_OFFM0   = 5'd26,
    PH_OFFM1   = 5'd27,
    PH_AFTOFF  = 5'd28,
    PH_AFTZ    = 5'd29
  } phase_e;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_TEE   = 8'h54;
  localparam logic [7:0] CH_ZED   = 8'h5A;

  localparam int unsigned FracDigits = 3;

  // Number of days in a month of a common year; zero for codes that are no month.
  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] len;
    begin
      unique case (month)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
        4'd2:                                       len = 5'd28;
        default:                                    len = 5'd0;
      endcase
      return len;
    end
  endfunction

  // True when the two-digit number tens:units is a multiple of four.
  function automatic logic pair_div4(input logic [3:0] tens, input logic [3:0] units);
    begin
      if (tens[0] == 1'b0) begin
        return (units == 4'd0) || (units == 4'd4) || (units == 4'd8);
      end else begin
        return (units == 4'd2) || (units == 4'd6);
      end
    end
  endfunction

  // Gregorian leap year rule on four decimal digits, thousands first.
  function automatic logic leap_year(input logic [15:0] digits);
    logic hundreds_zero;
    begin
      hundreds_zero = (digits[7:4] == 4'd0) && (digits[3:0] == 4'd0);
      return pair_div4(digits[7:4], digits[3:0]) &&
             (!hundreds_zero || pair_div4(digits[15:12], digits[11:8]));
    end
  endfunction

endpackage

@@ src/idtc_in_if.sv @@
// Input channel of the date-time checker: one character or end mark per transfer.
// Depends on nothing.
`timescale 1ns / 1ps

interface idtc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_mark;

  modport source (output valid, output char_code, output end_mark, input ready);
  modport sink   (input valid, input char_code, input end_mark, output ready);
endinterface

@@ src/idtc_out_if.sv @@
// Output channel of the date-time checker: one verdict per transfer.
// Depends on nothing.
`timescale 1ns / 1ps

interface idtc_out_if;
  logic valid;
  logic ready;
  logic is_valid;

  modport source (output valid, output is_valid, input ready);
  modport sink   (input valid, input is_valid, output ready);
endinterface

@@ src/iso8601_datetime_checker.sv @@
// Top level of the ISO 8601 date-time checker.
// Depends on idtc_pkg, idtc_in_if and idtc_out_if.
`timescale 1ns / 1ps

// The block takes one character per cycle while its input is ready and checks
// the string against YYYY-MM-DDThh:mm:ss with optional fraction, offset and Z.
// A character transfer produces no result; an end mark produces one verdict,
// registered, on the cycle after its transfer, and clears the state
// for the next string. The input is ready whenever the verdict register is
// empty or being drained in the same cycle, so a continuous stream runs at one
// item per clock as long as the consumer keeps ready high.

module iso8601_datetime_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  idtc_in_if.sink     in_i,
  idtc_out_if.source  out_o
);
  import idtc_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  count_q, count_d;
  logic [15:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [3:0]  first_q, first_d;
  logic        failed_q;
  logic        out_valid_q;
  logic        is_valid_q;

  logic        accept;
  logic        char_ok;
  logic        is_dig;
  logic [7:0]  diff;
  logic [3:0]  dig;
  logic [4:0]  day_val;
  logic [4:0]  day_lim;
  logic        verdict;
  logic        tail_ok;
  phase_e      tail_phase;

  assign in_i.ready     = !out_valid_q || out_o.ready;
  assign accept         = in_i.valid && in_i.ready;
  assign out_o.valid    = out_valid_q;
  assign out_o.is_valid = is_valid_q;

  assign is_dig  = (in_i.char_code >= CH_ZERO) && (in_i.char_code <= CH_NINE);
  assign diff    = in_i.char_code - CH_ZERO;
  assign dig     = diff[3:0];
  assign day_val = ({1'b0, first_q} * 5'd10) + {1'b0, dig};
  assign day_lim = month_len(month_q) +
                   5'((month_q == 4'd2) && leap_year(year_q));

  assign verdict = !failed_q &&
                   ((phase_q == PH_AFTSEC) || (phase_q == PH_FRACN) ||
                    (phase_q == PH_AFTFRAC) || (phase_q == PH_AFTOFF) ||
                    (phase_q == PH_AFTZ));

  always_comb begin
    tail_ok    = 1'b1;
    tail_phase = PH_AFTZ;
    priority if ((in_i.char_code == CH_PLUS) || (in_i.char_code == CH_DASH)) begin
      tail_phase = PH_OFFH0;
    end else if (in_i.char_code == CH_ZED) begin
      tail_phase = PH_AFTZ;
    end else begin
      tail_ok = 1'b0;
    end
  end

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    year_d  = year_q;
    month_d = month_q;
    first_d = first_q;
    char_ok = 1'b0;
    unique case (phase_q)
      PH_YEAR0: begin
        char_ok = (in_i.char_code == CH_ONE) || (in_i.char_code == CH_TWO);
        year_d  = {year_q[11:0], dig};
        phase_d = PH_YEAR1;
      end
      PH_YEAR1, PH_YEAR2, PH_YEAR3: begin
        char_ok = is_dig;
        year_d  = {year_q[11:0], dig};
        phase_d = phase_e'(phase_q + 5'd1);
      end
      PH_DASH1, PH_DASH2: begin
        char_ok = (in_i.char_code == CH_DASH);
        phase_d = phase_e'(phase_q + 5'd1);
      end
      PH_COLON1, PH_COLON2, PH_COLON3: begin
        char_ok = (in_i.char_code == CH_COLON);
        phase_d = phase_e'(phase_q + 5'd1);
      end
      PH_TEE: begin
        char_ok = (in_i.char_code == CH_TEE);
        phase_d = PH_HOUR0;
      end
      PH_MON0: begin
        char_ok = is_dig && (dig <= 4'd1);
        first_d = dig;
        phase_d = PH_MON1;
      end
      PH_MON1: begin
        char_ok = is_dig && !((first_q == 4'd0) && (dig == 4'd0)) &&
                  !((first_q == 4'd1) && (dig > 4'd2));
        month_d = 4'(first_q * 4'd10) + dig;
        phase_d = PH_DASH2;
      end
      PH_DAY0: begin
        char_ok = is_dig && (dig <= 4'd3);
        first_d = dig;
        phase_d = PH_DAY1;
      end
      PH_DAY1: begin
        char_ok = is_dig && !((first_q == 4'd0) && (dig == 4'd0)) &&
                  !((first_q == 4'd3) && (dig > 4'd1)) && (day_val <= day_lim);
        phase_d = PH_TEE;
      end
      PH_HOUR0, PH_OFFH0: begin
        char_ok = is_dig && (dig <= 4'd2);
        first_d = dig;
        phase_d = phase_e'(phase_q + 5'd1);
      end
      PH_HOUR1, PH_OFFH1: begin
        char_ok = is_dig && !((first_q == 4'd2) && (dig > 4'd3));
        phase_d = phase_e'(phase_q + 5'd1);
      end
      PH_MIN0, PH_SEC0, PH_OFFM0: begin
        char_ok = is_dig && (dig <= 4'd5);
        first_d = dig;
        phase_d = phase_e'(phase_q + 5'd1);
      end
      PH_MIN1, PH_OFFM1: begin
        char_ok = is_dig;
        phase_d = phase_e'(phase_q + 5'd1);
      end
      PH_SEC1: begin
        char_ok = is_dig;
        phase_d = PH_AFTSEC;
      end
      PH_AFTSEC: begin
        if (in_i.char_code == CH_DOT) begin
          char_ok = 1'b1;
          phase_d = PH_FRAC0;
        end else begin
          char_ok = tail_ok;
          phase_d = tail_phase;
        end
      end
      PH_FRAC0: begin
        char_ok = is_dig;
        count_d = 2'd1;
        phase_d = PH_FRACN;
      end
      PH_FRACN: begin
        if (is_dig) begin
          char_ok = 1'b1;
          if ((count_q + 2'd1) >= 2'(FracDigits)) begin
            count_d = 2'd0;
            phase_d = PH_AFTFRAC;
          end else begin
            count_d = count_q + 2'd1;
          end
        end else begin
          char_ok = tail_ok;
          phase_d = tail_phase;
        end
      end
      PH_AFTFRAC: begin
        char_ok = tail_ok;
        phase_d = tail_phase;
      end
      PH_AFTOFF: begin
        char_ok = (in_i.char_code == CH_ZED);
        phase_d = PH_AFTZ;
      end
      default: begin
        char_ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_YEAR0;
      count_q  <= 2'd0;
      year_q   <= 16'd0;
      month_q  <= 4'd0;
      first_q  <= 4'd0;
      failed_q <= 1'b0;
    end else if (accept) begin
      if (in_i.end_mark) begin
        phase_q  <= PH_YEAR0;
        count_q  <= 2'd0;
        year_q   <= 16'd0;
        month_q  <= 4'd0;
        first_q  <= 4'd0;
        failed_q <= 1'b0;
      end else if (!failed_q) begin
        if (char_ok) begin
          phase_q <= phase_d;
          count_q <= count_d;
          year_q  <= year_d;
          month_q <= month_d;
          first_q <= first_d;
        end else begin
          failed_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && in_i.end_mark) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_i.end_mark) begin
      is_valid_q <= verdict;
    end
  end

endmodule
